[rtl/trp_pkg.sv]
// Shared types and constants for the timestamped record and playback store.
package trp_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_PLAY   = 1'b1;

   localparam logic [1:0] STATUS_OK             = 2'd0;
   localparam logic [1:0] STATUS_NOT_INCREASING = 2'd1;
   localparam logic [1:0] STATUS_FULL           = 2'd2;
   localparam logic [1:0] STATUS_EMPTY          = 2'd3;

   typedef struct packed {
      logic               has_value;
      logic [31:0]        value_in;
      logic               has_time;
      logic signed [31:0] time_now;
      logic               clear_recording;
   } trp_req_type;

   typedef struct packed {
      logic [31:0] value_out;
      logic        value_valid;
      logic        finished_playback;
      logic [1:0]  status;
   } trp_rsp_type;

endpackage

[rtl/timestamped_record_playback_top.sv]
// Record and playback store of (time, value) frames. A record transaction is handled in the
// cycle it is taken: a value transaction is held as pending, and a time transaction appends it
// when the time rises strictly. A playback time transaction reads the frame table through one
// synchronous read port, one frame per cycle: the seek starts at the cursor's frame, restarts
// at frame 0 when the time lies before that frame, and walks forward until a frame lies after
// the time or the last frame is reached. A mode change to record empties the table; a change
// to playback keeps it. No clearing pass is needed after reset. A finished result waits in an
// output register, so the next transaction is taken while it is still stalled.
module timestamped_record_playback_top
   import trp_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  trp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output trp_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int SB    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SEEK = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   // Frame table.
   logic [31:0]   times_mem [DEPTH];
   logic [SB-1:0] vals_mem  [DEPTH];

   logic signed [31:0] rd_time_ff;
   logic [SB-1:0]      rd_val_ff;

   logic [1:0]         state_ff,       state_in;
   logic               mode_ff,        mode_in;
   logic [CNT_W-1:0]   count_ff,       count_in;
   logic [SB-1:0]      pend_val_ff,    pend_val_in;
   logic               pend_valid_ff,  pend_valid_in;
   logic signed [31:0] last_time_ff,   last_time_in;
   logic               last_valid_ff,  last_valid_in;
   logic [IDX_W-1:0]   cursor_ff,      cursor_in;
   logic               cur_valid_ff,   cur_valid_in;
   logic               at_end_ff,      at_end_in;
   logic signed [31:0] t_ff,           t_in;
   logic [IDX_W-1:0]   idx_ff,         idx_in;
   logic [IDX_W-1:0]   i1_ff,          i1_in;
   logic [SB-1:0]      cur_val_ff,     cur_val_in;
   trp_rsp_type        rsp_ff,         rsp_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   trp_rsp_type        hold_ff,        hold_in;

   logic               req_accept;
   logic               out_free;
   logic               done;
   trp_rsp_type        res;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [31:0]        wr_time;
   logic [SB-1:0]      wr_val;
   logic               do_step;
   logic [IDX_W-1:0]   sel_i1;
   logic [SB-1:0]      sel_val;
   logic [CNT_W-1:0]   nxt_cnt;
   logic               fin_en;
   logic               fin_end;
   logic [IDX_W-1:0]   fin_i1;
   logic [SB-1:0]      fin_val;
   logic [CNT_W-1:0]   count_eff;
   logic               pend_eff;
   logic               last_eff;
   logic               cur_eff;
   logic [SB-1:0]      new_pend;

   assign req_stall  = (state_ff != S_IDLE) || csr_wr_en;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      pend_val_in   = pend_val_ff;
      pend_valid_in = pend_valid_ff;
      last_time_in  = last_time_ff;
      last_valid_in = last_valid_ff;
      cursor_in     = cursor_ff;
      cur_valid_in  = cur_valid_ff;
      at_end_in     = at_end_ff;
      t_in          = t_ff;
      idx_in        = idx_ff;
      i1_in         = i1_ff;
      cur_val_in    = cur_val_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      hold_in       = hold_ff;
      done          = 1'b0;
      res           = '0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_time       = req_data.time_now;
      wr_val        = pend_val_ff;
      do_step       = 1'b0;
      sel_i1        = idx_ff;
      sel_val       = rd_val_ff;
      nxt_cnt       = '0;
      fin_en        = 1'b0;
      fin_end       = 1'b0;
      fin_i1        = i1_ff;
      fin_val       = cur_val_ff;

      // Clear takes effect before the rest of the transaction.
      count_eff = req_data.clear_recording ? '0 : count_ff;
      pend_eff  = req_data.clear_recording ? 1'b0 : pend_valid_ff;
      last_eff  = req_data.clear_recording ? 1'b0 : last_valid_ff;
      cur_eff   = req_data.clear_recording ? 1'b0 : cur_valid_ff;
      new_pend  = req_data.has_value ? req_data.value_in[SB-1:0] : pend_val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               if (csr_wr_data != mode_ff) begin
                  if (csr_wr_data == MODE_RECORD) begin
                     count_in = '0;
                  end
                  pend_valid_in = 1'b0;
                  last_valid_in = 1'b0;
                  cur_valid_in  = 1'b0;
               end
               mode_in = csr_wr_data;
            end else if (req_accept) begin
               count_in      = count_eff;
               pend_valid_in = pend_eff;
               last_valid_in = last_eff;
               cur_valid_in  = cur_eff;
               done          = 1'b1;
               if (mode_ff == MODE_RECORD) begin
                  if (req_data.has_value) begin
                     pend_val_in   = new_pend;
                     pend_valid_in = 1'b1;
                  end
                  if (req_data.has_time && (pend_eff || req_data.has_value)) begin
                     if (last_eff && !(last_time_ff < req_data.time_now)) begin
                        res.status = STATUS_NOT_INCREASING;
                     end else if (count_eff >= CNT_W'(DEPTH)) begin
                        res.status    = STATUS_FULL;
                        pend_valid_in = 1'b0;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = count_eff[IDX_W-1:0];
                        wr_val          = new_pend;
                        count_in        = count_eff + CNT_W'(1);
                        last_time_in    = req_data.time_now;
                        last_valid_in   = 1'b1;
                        res.value_out   = 32'(new_pend);
                        res.value_valid = 1'b1;
                        pend_valid_in   = 1'b0;
                     end
                  end
               end else if (req_data.has_time) begin
                  if (count_eff == '0) begin
                     res.status = STATUS_EMPTY;
                  end else begin
                     done  = 1'b0;
                     rd_en = 1'b1;
                     // A cursor outside the table restarts at frame 0.
                     if (cur_eff && (CNT_W'(cursor_ff) < count_eff)) begin
                        rd_addr = cursor_ff;
                     end else begin
                        rd_addr = '0;
                     end
                     idx_in   = rd_addr;
                     t_in     = req_data.time_now;
                     state_in = S_SEEK;
                  end
               end
            end
         end
         S_SEEK: begin
            if (t_ff < rd_time_ff) begin
               if (idx_ff == '0) begin
                  // Time before the first frame: nothing is played.
                  done = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
                  idx_in  = '0;
               end
            end else begin
               do_step = 1'b1;
            end
         end
         S_WALK: begin
            if (t_ff < rd_time_ff) begin
               fin_en = 1'b1;
            end else begin
               do_step = 1'b1;
            end
         end
         S_HOLD: begin
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_step) begin
         i1_in      = sel_i1;
         cur_val_in = sel_val;
         nxt_cnt    = CNT_W'(sel_i1) + CNT_W'(1);
         if (nxt_cnt >= count_ff) begin
            fin_en  = 1'b1;
            fin_end = 1'b1;
            fin_i1  = sel_i1;
            fin_val = sel_val;
         end else begin
            rd_en    = 1'b1;
            rd_addr  = nxt_cnt[IDX_W-1:0];
            idx_in   = rd_addr;
            state_in = S_WALK;
         end
      end

      if (fin_en) begin
         done            = 1'b1;
         res.value_out   = 32'(fin_val);
         res.value_valid = !(cur_valid_ff && (cursor_ff == fin_i1));
         if (fin_end) begin
            res.finished_playback = !at_end_ff;
            at_end_in             = 1'b1;
         end else begin
            at_end_in = 1'b0;
         end
         cursor_in    = fin_i1;
         cur_valid_in = 1'b1;
      end

      if (state_ff == S_HOLD) begin
         if (out_free) begin
            rsp_in       = hold_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
      end else if (done) begin
         state_in = S_IDLE;
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Writes happen only in record mode and reads only in playback mode, and the mode
   // changes only while idle, so a read never meets a write to the same frame.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         times_mem[wr_addr] <= wr_time;
         vals_mem[wr_addr]  <= wr_val;
      end
      if (rd_en) begin
         rd_time_ff <= times_mem[rd_addr];
         rd_val_ff  <= vals_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_RECORD;
         count_ff      <= '0;
         pend_val_ff   <= '0;
         pend_valid_ff <= 1'b0;
         last_time_ff  <= '0;
         last_valid_ff <= 1'b0;
         cursor_ff     <= '0;
         cur_valid_ff  <= 1'b0;
         at_end_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         pend_val_ff   <= pend_val_in;
         pend_valid_ff <= pend_valid_in;
         last_time_ff  <= last_time_in;
         last_valid_ff <= last_valid_in;
         cursor_ff     <= cursor_in;
         cur_valid_ff  <= cur_valid_in;
         at_end_ff     <= at_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      t_ff       <= t_in;
      idx_ff     <= idx_in;
      i1_ff      <= i1_in;
      cur_val_ff <= cur_val_in;
      rsp_ff     <= rsp_in;
      hold_ff    <= hold_in;
   end

endmodule

[rtl/trp_checker.sv]
// Port-level checks for the record and playback store, bound to its top level.
module trp_checker
   import trp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input trp_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input trp_rsp_type rsp_data,
   input logic        csr_wr_en,
   input logic        csr_wr_data
);

   // A stalled result transaction stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // Any error status comes without a value event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> !rsp_data.value_valid)
      else $error("value event reported together with an error status");

   // The end-of-playback pulse only comes with a successful seek.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished_playback |-> (rsp_data.status == STATUS_OK))
      else $error("finished flag raised with an error status");

   // No result transaction is offered right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A register write holds off the input channel for that cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> req_stall)
      else $error("input transaction could be taken during a register write");

endmodule

bind timestamped_record_playback_top trp_checker u_trp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
